// ===== hdl/tun_pkg.sv =====
// Shared constants for the triangle unit normal pipeline.
package tun_pkg;

  localparam int TUN_COORD_BITS = 16;
  localparam int TUN_FRAC_BITS  = 14;
  localparam int TUN_MIN_VERTS  = 3;

endpackage

// ===== hdl/triangle_unit_normal.sv =====
// Pipelined unit face normal of a triangle: cross product, integer sqrt, Q1.F divide.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   vertex_count_i, a_x_i .. c_z_i
//   out      output     out_valid_o / out_ready_i normal_x_o .. normal_z_o, degenerate_o
//
// One transaction per cycle sustained while out_ready_i does not stall the output;
// the square root and divider resolve one bit per stage.
// Reset clears all valid bits and the valid flag of the input skid register.
// A stall at the output freezes every stage; a one-entry skid register at the input
// keeps in_ready_o registered and takes one more transaction during a stall.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_BITS       = TUN_COORD_BITS,
  parameter int NORMAL_FRAC_BITS = TUN_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         vertex_count_i,
  input  logic signed [COORD_BITS-1:0]       a_x_i,
  input  logic signed [COORD_BITS-1:0]       a_y_i,
  input  logic signed [COORD_BITS-1:0]       a_z_i,
  input  logic signed [COORD_BITS-1:0]       b_x_i,
  input  logic signed [COORD_BITS-1:0]       b_y_i,
  input  logic signed [COORD_BITS-1:0]       b_z_i,
  input  logic signed [COORD_BITS-1:0]       c_x_i,
  input  logic signed [COORD_BITS-1:0]       c_y_i,
  input  logic signed [COORD_BITS-1:0]       c_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic                               degenerate_o
);

  localparam int W  = COORD_BITS;
  localparam int F  = NORMAL_FRAC_BITS;
  localparam int EW = W + 1;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int MW = 2 * W + 2;
  localparam int H  = (MW + 1) / 2;
  localparam int HH = MW - H;
  localparam int SW = 2 * MW + 2;
  localparam int LW = MW + 1;
  localparam int TW = SW + 1;
  localparam int RW = LW + 1;
  localparam int QW = F + 1;
  localparam int NW = F + 2;

  typedef struct packed {
    logic                few;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } item_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             sgn;
    logic [2:0][MW-1:0]     mag;
  } side_t;

  item_t in_item, skid_q, cur;
  logic  skid_valid_q, cur_valid, adv;
  logic  out_valid_q;

  assign in_item = '{few: (vertex_count_i < 8'(TUN_MIN_VERTS)),
                     ax: a_x_i, ay: a_y_i, az: a_z_i,
                     bx: b_x_i, by: b_y_i, bz: b_z_i,
                     cx: c_x_i, cy: c_y_i, cz: c_z_i};

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !skid_valid_q;
  assign cur        = skid_valid_q ? skid_q : in_item;
  assign cur_valid  = skid_valid_q || in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (adv) begin
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && !skid_valid_q) begin
      skid_q <= in_item;
    end
  end

  // Stage registers
  logic                 v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic                 few1_q, few2_q, few3_q, few4_q;
  logic signed [EW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [PW-1:0] p_q [6];
  logic signed [CW-1:0] c_q [3];
  logic [2:0]           sgn4_q;
  logic [2:0][MW-1:0]   mag4_q;
  logic [2*HH-1:0]      hh5_q [3];
  logic [HH+H-1:0]      hl5_q [3];
  logic [2*H-1:0]       ll5_q [3];
  side_t                side5_q, side6_q;
  logic [2*MW-1:0]      sq6_q [3];

  logic                 sr_v_q    [LW+1];
  logic [SW-1:0]        sr_rem_q  [LW];
  logic [LW-1:0]        sr_root_q [LW+1];
  side_t                sr_side_q [LW+1];

  logic                 dv_v_q  [F+1];
  logic [2:0][RW-1:0]   dv_r_q  [F+1];
  logic [2:0][QW-1:0]   dv_qt_q [F+1];
  logic [LW-1:0]        dv_l_q  [F+1];
  logic [2:0]           dv_sg_q [F+1];
  logic                 dv_dg_q [F+1];

  logic signed [CW-1:0] c_neg [3];
  logic [2:0][H-1:0]    lo5;
  logic [2:0][HH-1:0]   hi5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_neg[i] = -c_q[i];
      lo5[i]   = mag4_q[i][H-1:0];
      hi5[i]   = mag4_q[i][MW-1:H];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      few1_q <= cur.few;
      e1x_q  <= $signed({cur.bx[W-1], cur.bx}) - $signed({cur.ax[W-1], cur.ax});
      e1y_q  <= $signed({cur.by[W-1], cur.by}) - $signed({cur.ay[W-1], cur.ay});
      e1z_q  <= $signed({cur.bz[W-1], cur.bz}) - $signed({cur.az[W-1], cur.az});
      e2x_q  <= $signed({cur.cx[W-1], cur.cx}) - $signed({cur.ax[W-1], cur.ax});
      e2y_q  <= $signed({cur.cy[W-1], cur.cy}) - $signed({cur.ay[W-1], cur.ay});
      e2z_q  <= $signed({cur.cz[W-1], cur.cz}) - $signed({cur.az[W-1], cur.az});

      few2_q <= few1_q;
      p_q[0] <= e1y_q * e2z_q;
      p_q[1] <= e1z_q * e2y_q;
      p_q[2] <= e1z_q * e2x_q;
      p_q[3] <= e1x_q * e2z_q;
      p_q[4] <= e1x_q * e2y_q;
      p_q[5] <= e1y_q * e2x_q;

      few3_q <= few2_q;
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= $signed({p_q[2*i][PW-1], p_q[2*i]})
                - $signed({p_q[2*i+1][PW-1], p_q[2*i+1]});
      end

      few4_q <= few3_q;
      for (int i = 0; i < 3; i++) begin
        sgn4_q[i] <= c_q[i][CW-1];
        mag4_q[i] <= c_q[i][CW-1] ? c_neg[i][MW-1:0] : c_q[i][MW-1:0];
      end

      side5_q.degen <= few4_q || (mag4_q == '0);
      side5_q.sgn   <= sgn4_q;
      side5_q.mag   <= mag4_q;
      for (int i = 0; i < 3; i++) begin
        hh5_q[i] <= hi5[i] * hi5[i];
        hl5_q[i] <= hi5[i] * lo5[i];
        ll5_q[i] <= lo5[i] * lo5[i];
      end

      side6_q <= side5_q;
      for (int i = 0; i < 3; i++) begin
        sq6_q[i] <= ((2*MW)'(hh5_q[i]) << (2*H)) + ((2*MW)'(hl5_q[i]) << (H+1))
                  + (2*MW)'(ll5_q[i]);
      end

      sr_side_q[0] <= side6_q;
      sr_root_q[0] <= '0;
      sr_rem_q[0]  <= SW'(sq6_q[0]) + SW'(sq6_q[1]) + SW'(sq6_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      sr_v_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q      <= cur_valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      sr_v_q[0] <= v6_q;
    end
  end

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    localparam int B = LW - 1 - k;
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = (TW'(sr_root_q[k]) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = {1'b0, sr_rem_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sr_v_q[k+1] <= sr_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_side_q[k+1] <= sr_side_q[k];
        sr_root_q[k+1] <= ge ? (sr_root_q[k] | (LW'(1) << B)) : sr_root_q[k];
      end
    end

    if (k < LW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sr_rem_q[k+1] <= ge ? (sr_rem_q[k] - trial[SW-1:0]) : sr_rem_q[k];
        end
      end
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_div
    logic               vin, dgin;
    logic [LW-1:0]      lin;
    logic [2:0]         sgin;
    logic [2:0][RW-1:0] rin, rs, rn;
    logic [2:0][QW-1:0] qin, qn;

    if (j == 0) begin : g_first
      assign vin  = sr_v_q[LW];
      assign dgin = sr_side_q[LW].degen;
      assign lin  = sr_root_q[LW];
      assign sgin = sr_side_q[LW].sgn;
      assign qin  = '0;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rin[i] = RW'(sr_side_q[LW].mag[i]);
        assign rs[i]  = rin[i];
      end
    end else begin : g_next
      assign vin  = dv_v_q[j-1];
      assign dgin = dv_dg_q[j-1];
      assign lin  = dv_l_q[j-1];
      assign sgin = dv_sg_q[j-1];
      assign qin  = dv_qt_q[j-1];
      assign rin  = dv_r_q[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rs[i] = {rin[i][RW-2:0], 1'b0};
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_step
      logic ge;
      assign ge    = rs[i] >= {1'b0, lin};
      assign rn[i] = ge ? (rs[i] - {1'b0, lin}) : rs[i];
      assign qn[i] = {qin[i][QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (adv) begin
        dv_v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_dg_q[j] <= dgin;
        dv_l_q[j]  <= lin;
        dv_sg_q[j] <= sgin;
        dv_qt_q[j] <= qn;
        dv_r_q[j]  <= rn;
      end
    end
  end

  localparam logic [QW-1:0] QLIM = QW'(1) << F;

  logic [2:0][NW-1:0] nrm_d;
  logic [2:0][NW-1:0] nrm_q;
  logic               dg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QW-1:0] qc;
      qc = (dv_qt_q[F][i] > QLIM) ? QLIM : dv_qt_q[F][i];
      if (dv_dg_q[F]) begin
        nrm_d[i] = '0;
      end else if (dv_sg_q[F][i]) begin
        nrm_d[i] = -NW'(qc);
      end else begin
        nrm_d[i] = NW'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v_q[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nrm_q <= nrm_d;
      dg_q  <= dv_dg_q[F];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = $signed(nrm_q[0]);
  assign normal_y_o   = $signed(nrm_q[1]);
  assign normal_z_o   = $signed(nrm_q[2]);
  assign degenerate_o = dg_q;

endmodule

// ===== hdl/tun_checker.sv =====
// Port-level assertions for the triangle unit normal pipeline, with its bind.
module tun_checker import tun_pkg::*; #(
  parameter int COORD_BITS       = TUN_COORD_BITS,
  parameter int NORMAL_FRAC_BITS = TUN_FRAC_BITS
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [7:0]                         vertex_count_i,
  input logic signed [COORD_BITS-1:0]       a_x_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  input logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  input logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  input logic                               degenerate_o
);

  localparam int LIM = 1 << NORMAL_FRAC_BITS;

  logic unused_in;
  assign unused_in = in_valid_i ^ in_ready_o ^ (^vertex_count_i) ^ (^a_x_i);

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0)
    else $error("degenerate transaction with nonzero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o >= -LIM && normal_x_o <= LIM &&
                    normal_y_o >= -LIM && normal_y_o <= LIM &&
                    normal_z_o >= -LIM && normal_z_o <= LIM)
    else $error("normal component outside Q1 range");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped during stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(normal_x_o) && $stable(normal_y_o) &&
                                    $stable(normal_z_o) && $stable(degenerate_o))
    else $error("output payload changed during stall");

endmodule

bind triangle_unit_normal tun_checker #(
  .COORD_BITS(COORD_BITS),
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tun_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .vertex_count_i(vertex_count_i),
  .a_x_i(a_x_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .normal_x_o(normal_x_o),
  .normal_y_o(normal_y_o),
  .normal_z_o(normal_z_o),
  .degenerate_o(degenerate_o)
);
